FILE: rtl/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Types, constants and stage map of the ray versus box slab test.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int ID_BITS  = 16;
    localparam int COORD_W  = 32;
    localparam int DIR_W    = 18;
    localparam int DIST_W   = 31;
    localparam int LAYER_W  = 32;
    localparam int FILT_W   = 33;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int QUO_W    = DIST_W + 2;
    localparam int FRAC_W   = 16;
    localparam int NUM_W    = DIFF_W + FRAC_W;
    localparam int QBITS    = DIST_W;
    localparam int PROD_W   = DIR_W + COORD_W;

    localparam int DIV_LAT    = QBITS + 3;
    localparam int DIV_FIRST  = 2;
    localparam int SLAB_LAT   = 3;
    localparam int SLAB_FIRST = DIV_FIRST + DIV_LAT;
    localparam int PT_LAT     = 3;
    localparam int PT_FIRST   = SLAB_FIRST + SLAB_LAT;
    localparam int NST        = PT_FIRST + PT_LAT;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIR_W-1:0]   dir_t;
    typedef logic [DIST_W-1:0]         dist_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [QUO_W-1:0]   quo_t;

    localparam quo_t FAR_INF = {1'b0, {(QUO_W-1){1'b1}}};

    typedef enum logic [2:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_ORIGIN_Z,
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z,
        REG_MAX_DIST,
        REG_FILTER
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z,
        AXIS_NONE
    } axis_t;

    typedef struct packed {
        coord_t              origin_x;
        coord_t              origin_y;
        coord_t              origin_z;
        dir_t                dir_x;
        dir_t                dir_y;
        dir_t                dir_z;
        dist_t               max_distance;
        logic [FILT_W-1:0]   filter_word;
    } cfg_t;

    localparam dir_t              DIR_ONE      = dir_t'(65536);
    localparam dist_t             MAX_DIST_RST = dist_t'(65536);
    localparam logic [FILT_W-1:0] FILTER_RST   = {1'b0, {LAYER_W{1'b1}}};

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic               pass;
        logic [2:0]         par;
    } side_t;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic               pass;
        quo_t               near;
        quo_t               far;
        axis_t              axis;
        logic               sign;
    } slab_res_t;

endpackage

FILE: rtl/rbs_if.sv
// ----------------------------------------------------------------------------
// rbs_in_if / rbs_out_if
// Valid/ready channels for box items and hit results.
// ----------------------------------------------------------------------------
interface rbs_in_if import rbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_BITS-1:0] body_id;
    coord_t             min_x;
    coord_t             min_y;
    coord_t             min_z;
    coord_t             max_x;
    coord_t             max_y;
    coord_t             max_z;
    logic [LAYER_W-1:0] body_layer;
    logic               is_trigger;

    modport source (output valid, body_id, min_x, min_y, min_z, max_x, max_y, max_z,
                    body_layer, is_trigger, input ready);
    modport sink   (input valid, body_id, min_x, min_y, min_z, max_x, max_y, max_z,
                    body_layer, is_trigger, output ready);
endinterface

interface rbs_out_if import rbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_BITS-1:0] hit_body;
    logic               hit;
    dist_t              distance;
    axis_t              normal_axis;
    logic               normal_sign;
    coord_t             point_x;
    coord_t             point_y;
    coord_t             point_z;

    modport source (output valid, hit_body, hit, distance, normal_axis, normal_sign,
                    point_x, point_y, point_z, input ready);
    modport sink   (input valid, hit_body, hit, distance, normal_axis, normal_sign,
                    point_x, point_y, point_z, output ready);
endinterface

FILE: rtl/rbs_cfg.sv
// ----------------------------------------------------------------------------
// rbs_cfg
// Ray configuration registers with a plain write port.
// ----------------------------------------------------------------------------
module rbs_cfg import rbs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [FILT_W-1:0] cfg_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_ORIGIN_X: cfg_next.origin_x     = cfg_data[COORD_W-1:0];
                REG_ORIGIN_Y: cfg_next.origin_y     = cfg_data[COORD_W-1:0];
                REG_ORIGIN_Z: cfg_next.origin_z     = cfg_data[COORD_W-1:0];
                REG_DIR_X:    cfg_next.dir_x        = cfg_data[DIR_W-1:0];
                REG_DIR_Y:    cfg_next.dir_y        = cfg_data[DIR_W-1:0];
                REG_DIR_Z:    cfg_next.dir_z        = cfg_data[DIR_W-1:0];
                REG_MAX_DIST: cfg_next.max_distance = cfg_data[DIST_W-1:0];
                REG_FILTER:   cfg_next.filter_word  = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.origin_z     <= '0;
            cfg_reg.dir_x        <= DIR_ONE;
            cfg_reg.dir_y        <= '0;
            cfg_reg.dir_z        <= '0;
            cfg_reg.max_distance <= MAX_DIST_RST;
            cfg_reg.filter_word  <= FILTER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/rbs_div.sv
// ----------------------------------------------------------------------------
// rbs_div
// Pipelined signed slab-distance divider, one quotient bit per stage,
// quotient saturated to plus or minus 2^31.
// ----------------------------------------------------------------------------
module rbs_div import rbs_pkg::*; (
    input  logic               clk,
    input  logic [DIV_LAT-1:0] en,
    input  diff_t              num,
    input  dir_t               den,
    output quo_t               quo
);

    logic [DIFF_W-1:0] num_mag;
    logic [DIR_W-1:0]  den_mag;

    logic [NUM_W-1:0]  n_abs_reg;
    logic [DIR_W-1:0]  d_abs_reg;
    logic              neg_abs_reg;

    logic [NUM_W-1:0]  rem_reg [QBITS+1];
    logic [DIR_W-1:0]  d_reg   [QBITS+1];
    logic [QBITS-1:0]  q_reg   [QBITS+1];
    logic              ovf_reg [QBITS+1];
    logic              neg_reg [QBITS+1];

    logic [QUO_W-1:0]  mag;
    quo_t              quo_reg;

    assign num_mag = num[DIFF_W-1] ? (~num + DIFF_W'(1)) : num;
    assign den_mag = den[DIR_W-1] ? (~den + DIR_W'(1)) : den;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            n_abs_reg   <= {num_mag, {FRAC_W{1'b0}}};
            d_abs_reg   <= den_mag;
            neg_abs_reg <= num[DIFF_W-1] ^ den[DIR_W-1];
        end
        if (en[1])
        begin
            rem_reg[0] <= n_abs_reg;
            d_reg[0]   <= d_abs_reg;
            q_reg[0]   <= '0;
            ovf_reg[0] <= n_abs_reg >= (NUM_W'(d_abs_reg) << QBITS);
            neg_reg[0] <= neg_abs_reg;
        end
    end

    for (genvar j = 0; j < QBITS; j++)
    begin : g_step
        logic [NUM_W-1:0] dsh;
        logic             take;

        assign dsh  = NUM_W'(d_reg[j]) << (QBITS - 1 - j);
        assign take = !ovf_reg[j] && (rem_reg[j] >= dsh);

        always_ff @(posedge clk)
        begin
            if (en[j+2])
            begin
                rem_reg[j+1] <= take ? (rem_reg[j] - dsh) : rem_reg[j];
                q_reg[j+1]   <= q_reg[j] | (take ? (QBITS'(1) << (QBITS - 1 - j)) : '0);
                d_reg[j+1]   <= d_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    assign mag = ovf_reg[QBITS] ? (QUO_W'(1) << QBITS) : QUO_W'(q_reg[QBITS]);

    always_ff @(posedge clk)
    begin
        if (en[DIV_LAT-1])
        begin
            quo_reg <= neg_reg[QBITS] ? quo_t'(~mag + QUO_W'(1)) : quo_t'(mag);
        end
    end

    assign quo = quo_reg;

endmodule

FILE: rtl/rbs_slab.sv
// ----------------------------------------------------------------------------
// rbs_slab
// Orders slab distances per axis and reduces them to entry/exit distance
// and entry face over three stages.
// ----------------------------------------------------------------------------
module rbs_slab import rbs_pkg::*; (
    input  logic                clk,
    input  logic [SLAB_LAT-1:0] en,
    input  quo_t                t_lo [3],
    input  quo_t                t_hi [3],
    input  side_t               side,
    input  dist_t               max_distance,
    output slab_res_t           res
);

    quo_t      e_next [3];
    quo_t      x_next [3];
    logic      sw     [3];

    quo_t      e_reg  [3];
    quo_t      x_reg  [3];
    logic [2:0] sg_reg;
    side_t     s0_reg;

    quo_t      nxy_reg;
    quo_t      fxy_reg;
    quo_t      ez_reg;
    quo_t      fz_reg;
    axis_t     axy_reg;
    logic      sxy_reg;
    logic      sz_reg;
    side_t     s1_reg;

    quo_t      nb;
    axis_t     ab;
    logic      sb;
    slab_res_t res_next;
    slab_res_t res_reg;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        assign sw[a]     = !side.par[a] && (t_lo[a] > t_hi[a]);
        assign e_next[a] = side.par[a] ? '0 : (sw[a] ? t_hi[a] : t_lo[a]);
        assign x_next[a] = side.par[a] ? FAR_INF : (sw[a] ? t_lo[a] : t_hi[a]);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int a = 0; a < 3; a++)
            begin
                e_reg[a]  <= e_next[a];
                x_reg[a]  <= x_next[a];
                sg_reg[a] <= sw[a];
            end
            s0_reg <= side;
        end
        if (en[1])
        begin
            if (e_reg[1] > e_reg[0])
            begin
                nxy_reg <= e_reg[1];
                axy_reg <= AXIS_Y;
                sxy_reg <= sg_reg[1];
            end
            else
            begin
                nxy_reg <= e_reg[0];
                axy_reg <= AXIS_X;
                sxy_reg <= sg_reg[0];
            end
            fxy_reg <= (x_reg[1] < x_reg[0]) ? x_reg[1] : x_reg[0];
            fz_reg  <= (x_reg[2] < quo_t'({2'b00, max_distance})) ?
                       x_reg[2] : quo_t'({2'b00, max_distance});
            ez_reg  <= e_reg[2];
            sz_reg  <= sg_reg[2];
            s1_reg  <= s0_reg;
        end
        if (en[2])
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        if (nxy_reg > quo_t'(0))
        begin
            nb = nxy_reg;
            ab = axy_reg;
            sb = sxy_reg;
        end
        else
        begin
            nb = '0;
            ab = AXIS_NONE;
            sb = 1'b0;
        end
        res_next.id   = s1_reg.id;
        res_next.pass = s1_reg.pass;
        res_next.far  = (fz_reg < fxy_reg) ? fz_reg : fxy_reg;
        if (ez_reg > nb)
        begin
            res_next.near = ez_reg;
            res_next.axis = AXIS_Z;
            res_next.sign = sz_reg;
        end
        else
        begin
            res_next.near = nb;
            res_next.axis = ab;
            res_next.sign = sb;
        end
    end

    assign res = res_reg;

endmodule

FILE: rtl/rbs_point.sv
// ----------------------------------------------------------------------------
// rbs_point
// Hit decision and hit point: multiply, scale toward zero, add origin with
// saturation; last stage is the output register.
// ----------------------------------------------------------------------------
module rbs_point import rbs_pkg::*; (
    input  logic               clk,
    input  logic [PT_LAT-1:0]  en,
    input  slab_res_t          res,
    input  dir_t               dir [3],
    input  coord_t             org [3],
    output logic [ID_BITS-1:0] hit_body,
    output logic               hit,
    output dist_t              distance,
    output axis_t              normal_axis,
    output logic               normal_sign,
    output coord_t             point [3]
);

    localparam int SC_W  = PROD_W - FRAC_W;
    localparam int SUM_W = SC_W + 1;

    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [PROD_W-1:0] prod_reg  [3];
    logic                     hit0_reg;
    dist_t                    dist0_reg;
    axis_t                    axis0_reg;
    logic                     sign0_reg;
    logic [ID_BITS-1:0]       id0_reg;

    logic signed [SC_W-1:0]   sc_next [3];
    logic signed [SC_W-1:0]   sc_reg  [3];
    logic                     hit1_reg;
    dist_t                    dist1_reg;
    axis_t                    axis1_reg;
    logic                     sign1_reg;
    logic [ID_BITS-1:0]       id1_reg;

    logic signed [SUM_W-1:0]  sum [3];
    coord_t                   sat [3];

    logic [ID_BITS-1:0]       id_reg;
    logic                     hit_reg;
    dist_t                    dist_reg;
    axis_t                    axis_reg;
    logic                     sign_reg;
    coord_t                   point_reg [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        assign prod_next[a] = $signed(dir[a]) * $signed({1'b0, res.near[DIST_W-1:0]});
        assign sc_next[a]   = prod_reg[a][PROD_W-1:FRAC_W]
                              + SC_W'(prod_reg[a][PROD_W-1] && (prod_reg[a][FRAC_W-1:0] != '0));
        assign sum[a]       = $signed({{(SUM_W-COORD_W){org[a][COORD_W-1]}}, org[a]})
                              + $signed({sc_reg[a][SC_W-1], sc_reg[a]});
        assign sat[a]       = (sum[a] > $signed(SUM_W'({1'b0, {(COORD_W-1){1'b1}}}))) ?
                              {1'b0, {(COORD_W-1){1'b1}}} :
                              (sum[a] < -$signed(SUM_W'({1'b1, {(COORD_W-1){1'b0}}}))) ?
                              {1'b1, {(COORD_W-1){1'b0}}} : sum[a][COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg  <= prod_next;
            hit0_reg  <= res.pass && (res.near <= res.far);
            dist0_reg <= res.near[DIST_W-1:0];
            axis0_reg <= res.axis;
            sign0_reg <= res.sign;
            id0_reg   <= res.id;
        end
        if (en[1])
        begin
            sc_reg    <= sc_next;
            hit1_reg  <= hit0_reg;
            dist1_reg <= dist0_reg;
            axis1_reg <= axis0_reg;
            sign1_reg <= sign0_reg;
            id1_reg   <= id0_reg;
        end
        if (en[2])
        begin
            id_reg   <= id1_reg;
            hit_reg  <= hit1_reg;
            dist_reg <= hit1_reg ? dist1_reg : '0;
            axis_reg <= hit1_reg ? axis1_reg : AXIS_NONE;
            sign_reg <= hit1_reg && sign1_reg;
            for (int a = 0; a < 3; a++)
            begin
                point_reg[a] <= hit1_reg ? sat[a] : '0;
            end
        end
    end

    assign hit_body    = id_reg;
    assign hit         = hit_reg;
    assign distance    = dist_reg;
    assign normal_axis = axis_reg;
    assign normal_sign = sign_reg;
    assign point       = point_reg;

endmodule

FILE: rtl/ray_box_slab_test.sv
// Throughput: one item per cycle unless a stall holds the pipeline; the slab dividers are 34-stage pipelines,
//   one quotient bit per stage, and every stage holds one item.
// Stalls: each stage advances while it or any later stage holds a bubble or
//   the output is taken, so a waiting result still lets items enter while a bubble remains.
// Reset: valid bits clear, ray registers take their reset values.
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray versus axis-aligned box test, slab method, Q16.16, one item per cycle when not stalled.
// ----------------------------------------------------------------------------
module ray_box_slab_test import rbs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [FILT_W-1:0] cfg_data,
    rbs_in_if.sink            body,
    rbs_out_if.source         result
);

    cfg_t               cfg;
    coord_t             org [3];
    dir_t               dir [3];

    logic [NST-1:0]     en;
    logic [NST-1:0]     v_reg;

    logic [ID_BITS-1:0] id0_reg;
    coord_t             lo0_reg [3];
    coord_t             hi0_reg [3];
    logic [LAYER_W-1:0] layer0_reg;
    logic               trig0_reg;

    logic [2:0]         par;
    logic [2:0]         in_slab;
    side_t              side1_next;
    diff_t              dlo_reg [3];
    diff_t              dhi_reg [3];
    side_t              side1_reg;

    side_t              side_reg [DIV_LAT];
    quo_t               t_lo [3];
    quo_t               t_hi [3];
    slab_res_t          slab_res;
    coord_t             point [3];

    rbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign org[0] = cfg.origin_x;
    assign org[1] = cfg.origin_y;
    assign org[2] = cfg.origin_z;
    assign dir[0] = cfg.dir_x;
    assign dir[1] = cfg.dir_y;
    assign dir[2] = cfg.dir_z;

    for (genvar k = 0; k < NST; k++)
    begin : g_en
        assign en[k] = result.ready || !(&v_reg[NST-1:k]);
    end

    assign body.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= body.valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            id0_reg    <= body.body_id;
            lo0_reg[0] <= body.min_x;
            lo0_reg[1] <= body.min_y;
            lo0_reg[2] <= body.min_z;
            hi0_reg[0] <= body.max_x;
            hi0_reg[1] <= body.max_y;
            hi0_reg[2] <= body.max_z;
            layer0_reg <= body.body_layer;
            trig0_reg  <= body.is_trigger;
        end
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_pre
        assign par[a]     = (dir[a] == '0);
        assign in_slab[a] = (org[a] >= lo0_reg[a]) && (org[a] <= hi0_reg[a]);

        always_ff @(posedge clk)
        begin
            if (en[1])
            begin
                dlo_reg[a] <= $signed({lo0_reg[a][COORD_W-1], lo0_reg[a]})
                              - $signed({org[a][COORD_W-1], org[a]});
                dhi_reg[a] <= $signed({hi0_reg[a][COORD_W-1], hi0_reg[a]})
                              - $signed({org[a][COORD_W-1], org[a]});
            end
        end

        rbs_div u_div_lo (
            .clk (clk),
            .en  (en[DIV_FIRST +: DIV_LAT]),
            .num (dlo_reg[a]),
            .den (dir[a]),
            .quo (t_lo[a])
        );

        rbs_div u_div_hi (
            .clk (clk),
            .en  (en[DIV_FIRST +: DIV_LAT]),
            .num (dhi_reg[a]),
            .den (dir[a]),
            .quo (t_hi[a])
        );
    end

    always_comb
    begin
        side1_next.id   = id0_reg;
        side1_next.par  = par;
        side1_next.pass = ((layer0_reg & cfg.filter_word[LAYER_W-1:0]) != '0)
                          && (!trig0_reg || cfg.filter_word[FILT_W-1])
                          && ((~par | in_slab) == 3'b111);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side1_reg <= side1_next;
        end
        if (en[DIV_FIRST])
        begin
            side_reg[0] <= side1_reg;
        end
        for (int j = 1; j < DIV_LAT; j++)
        begin
            if (en[DIV_FIRST+j])
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    rbs_slab u_slab (
        .clk          (clk),
        .en           (en[SLAB_FIRST +: SLAB_LAT]),
        .t_lo         (t_lo),
        .t_hi         (t_hi),
        .side         (side_reg[DIV_LAT-1]),
        .max_distance (cfg.max_distance),
        .res          (slab_res)
    );

    rbs_point u_point (
        .clk         (clk),
        .en          (en[PT_FIRST +: PT_LAT]),
        .res         (slab_res),
        .dir         (dir),
        .org         (org),
        .hit_body    (result.hit_body),
        .hit         (result.hit),
        .distance    (result.distance),
        .normal_axis (result.normal_axis),
        .normal_sign (result.normal_sign),
        .point       (point)
    );

    assign result.point_x = point[0];
    assign result.point_y = point[1];
    assign result.point_z = point[2];
    assign result.valid   = v_reg[NST-1];

endmodule

FILE: rtl/rbs_chk.sv
// ----------------------------------------------------------------------------
// rbs_chk
// Port-level checks of the slab test, bound to the top level.
// ----------------------------------------------------------------------------
module rbs_chk import rbs_pkg::*; (
    input logic   clk,
    input logic   rst_n,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input logic   hit,
    input dist_t  distance,
    input axis_t  normal_axis,
    input logic   normal_sign,
    input coord_t point_x,
    input coord_t point_y,
    input coord_t point_z
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> distance == '0 && normal_axis == AXIS_NONE && !normal_sign
                               && point_x == '0 && point_y == '0 && point_z == '0)
        else $error("miss carries nonzero fields");

    a_face_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> (normal_axis == AXIS_NONE) == (distance == '0))
        else $error("entry face and entry distance disagree");

    a_none_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && normal_axis == AXIS_NONE |-> !normal_sign)
        else $error("sign set without entry face");

endmodule

bind ray_box_slab_test rbs_chk u_rbs_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (body.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .hit         (result.hit),
    .distance    (result.distance),
    .normal_axis (result.normal_axis),
    .normal_sign (result.normal_sign),
    .point_x     (result.point_x),
    .point_y     (result.point_y),
    .point_z     (result.point_z)
);

FILE: dv/ray_box_slab_test_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_box_slab_test_test
// Streams box items through the slab tester under several ray settings and
// compares every result item with a fixed-point slab predictor kept here.
// Both channels idle at random; one phase holds the result side off for a
// long stretch so the pipeline fills and stalls the box side.
// ----------------------------------------------------------------------------
module ray_box_slab_test_test import rbs_pkg::*; ();

    localparam longint Q = 65536;

    typedef struct packed {
        logic [ID_BITS-1:0] body_id;
        coord_t             min_x;
        coord_t             min_y;
        coord_t             min_z;
        coord_t             max_x;
        coord_t             max_y;
        coord_t             max_z;
        logic [LAYER_W-1:0] body_layer;
        logic               is_trigger;
    } box_t;

    typedef struct packed {
        logic [ID_BITS-1:0] hit_body;
        logic               hit;
        dist_t              distance;
        axis_t              normal_axis;
        logic               normal_sign;
        coord_t             point_x;
        coord_t             point_y;
        coord_t             point_z;
    } hit_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [FILT_W-1:0] cfg_data;

    rbs_in_if  body_if ();
    rbs_out_if res_if ();

    ray_box_slab_test u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .body      (body_if.sink),
        .result    (res_if.source)
    );

    coord_t            ray_ox, ray_oy, ray_oz;
    dir_t              ray_dx, ray_dy, ray_dz;
    dist_t             ray_max;
    logic [FILT_W-1:0] ray_filter;

    hit_t pending_hits[$];
    int   errors;
    int   boxes_sent;
    int   hits_seen;
    int   ray_settings;
    int   hold_req;
    bit   quiet;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("ray_box_slab_test: mismatch");
        $finish;
    end

    function automatic hit_t predict_hit(box_t b);
        longint org[3], dir[3], lo[3], hi[3];
        longint nearv, farv, t0, t1, tmp, p;
        logic   pass, sg, sgn;
        axis_t  ax;
        coord_t pt[3];
        hit_t   r;
        org[0] = ray_ox; org[1] = ray_oy; org[2] = ray_oz;
        dir[0] = ray_dx; dir[1] = ray_dy; dir[2] = ray_dz;
        lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
        hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
        nearv = 0;
        farv  = longint'(ray_max);
        ax    = AXIS_NONE;
        sgn   = 1'b0;
        pass  = ((b.body_layer & ray_filter[LAYER_W-1:0]) != 0)
                && !(b.is_trigger && !ray_filter[LAYER_W]);
        for (int a = 0; a < 3; a++)
        begin
            if (pass)
            begin
                if (dir[a] == 0)
                begin
                    if (org[a] < lo[a] || org[a] > hi[a])
                        pass = 1'b0;
                end
                else
                begin
                    t0 = ((lo[a] - org[a]) * Q) / dir[a];
                    t1 = ((hi[a] - org[a]) * Q) / dir[a];
                    sg = 1'b0;
                    if (t0 > t1)
                    begin
                        tmp = t0; t0 = t1; t1 = tmp;
                        sg = 1'b1;
                    end
                    if (t0 > nearv)
                    begin
                        nearv = t0;
                        ax    = axis_t'(a);
                        sgn   = sg;
                    end
                    if (t1 < farv)
                        farv = t1;
                    if (nearv > farv)
                        pass = 1'b0;
                end
            end
        end
        if (nearv > longint'(ray_max))
            pass = 1'b0;
        r = '0;
        r.hit_body    = b.body_id;
        r.normal_axis = AXIS_NONE;
        if (pass)
        begin
            for (int a = 0; a < 3; a++)
            begin
                p = org[a] + (dir[a] * nearv) / Q;
                if (p > 64'sd2147483647)
                    p = 64'sd2147483647;
                if (p < -64'sd2147483648)
                    p = -64'sd2147483648;
                pt[a] = coord_t'(p);
            end
            r.hit         = 1'b1;
            r.distance    = dist_t'(nearv);
            r.normal_axis = ax;
            r.normal_sign = sgn;
            r.point_x     = pt[0];
            r.point_y     = pt[1];
            r.point_z     = pt[2];
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_box(box_t b);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            body_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        body_if.valid      <= 1'b1;
        body_if.body_id    <= b.body_id;
        body_if.min_x      <= b.min_x;
        body_if.min_y      <= b.min_y;
        body_if.min_z      <= b.min_z;
        body_if.max_x      <= b.max_x;
        body_if.max_y      <= b.max_y;
        body_if.max_z      <= b.max_z;
        body_if.body_layer <= b.body_layer;
        body_if.is_trigger <= b.is_trigger;
        do
            @(posedge clk);
        while (!body_if.ready);
        pending_hits = {pending_hits, predict_hit(b)};
        boxes_sent++;
    endtask

    task automatic drain();
        body_if.valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (48) @(posedge clk);
    endtask

    task automatic apply_ray(coord_t ox, coord_t oy, coord_t oz, dir_t dx, dir_t dy,
                             dir_t dz, dist_t md, logic [FILT_W-1:0] fw);
        logic [FILT_W-1:0] vals[8];
        vals[REG_ORIGIN_X] = {ox[COORD_W-1], ox};
        vals[REG_ORIGIN_Y] = {oy[COORD_W-1], oy};
        vals[REG_ORIGIN_Z] = {oz[COORD_W-1], oz};
        vals[REG_DIR_X]    = FILT_W'(dx);
        vals[REG_DIR_Y]    = FILT_W'(dy);
        vals[REG_DIR_Z]    = FILT_W'(dz);
        vals[REG_MAX_DIST] = FILT_W'(md);
        vals[REG_FILTER]   = fw;
        for (int i = 0; i < 8; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        ray_ox = ox; ray_oy = oy; ray_oz = oz;
        ray_dx = dx; ray_dy = dy; ray_dz = dz;
        ray_max    = md;
        ray_filter = fw;
        ray_settings++;
    endtask

    function automatic box_t mk_box(logic [15:0] id, longint lx, longint ly, longint lz,
                                    longint hx, longint hy, longint hz,
                                    logic [31:0] layer, logic trig);
        box_t b;
        b.body_id = id;
        b.min_x = coord_t'(lx); b.min_y = coord_t'(ly); b.min_z = coord_t'(lz);
        b.max_x = coord_t'(hx); b.max_y = coord_t'(hy); b.max_z = coord_t'(hz);
        b.body_layer = layer;
        b.is_trigger = trig;
        return b;
    endfunction

    function automatic box_t rand_box();
        box_t   b;
        longint org[3], lo[3], hi[3], span;
        org[0] = ray_ox; org[1] = ray_oy; org[2] = ray_oz;
        b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             17'($urandom)};
        if ($urandom_range(0, 9) < 7)
        begin
            span = longint'($urandom_range(1, 8)) * Q;
            for (int a = 0; a < 3; a++)
            begin
                lo[a] = org[a] + longint'($urandom_range(0, 2 * span)) - span;
                hi[a] = lo[a] + longint'($urandom_range(0, span));
            end
            b = mk_box(b.body_id, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], b.body_layer,
                       $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) != 0)
                b.body_layer |= ray_filter[LAYER_W-1:0];
        end
        if (b.body_layer == 0)
            b.body_layer = 32'h1;
        return b;
    endfunction

    function automatic dir_t rand_dir();
        case ($urandom_range(0, 5))
            0: return dir_t'(0);
            1: return dir_t'(65536);
            2: return dir_t'(-65536);
            default: return dir_t'($urandom);
        endcase
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            0: return coord_t'(32'h8000_0000);
            1: return coord_t'(32'h7FFF_FFFF);
            default: return coord_t'(longint'($urandom_range(0, 32 * Q)) - 16 * Q);
        endcase
    endfunction

    function automatic dist_t rand_max();
        case ($urandom_range(0, 5))
            0: return dist_t'(1);
            1: return dist_t'(32'h7FFF_FFFF);
            default: return dist_t'($urandom_range(Q, 16 * Q));
        endcase
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    initial
    begin
        hit_t exp_h;
        int   stall_left;
        res_if.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
            begin
                if (pending_hits.size() == 0)
                begin
                    $error("result item for body %0d with no box pending", res_if.hit_body);
                    errors++;
                end
                else
                begin
                    exp_h = pending_hits.pop_front();
                    check_field("hit_body", exp_h.hit_body, res_if.hit_body);
                    check_field("hit", exp_h.hit, res_if.hit);
                    check_field("distance", exp_h.distance, res_if.distance);
                    check_field("normal_axis", exp_h.normal_axis, res_if.normal_axis);
                    check_field("normal_sign", exp_h.normal_sign, res_if.normal_sign);
                    check_field("point_x", exp_h.point_x, res_if.point_x);
                    check_field("point_y", exp_h.point_y, res_if.point_y);
                    check_field("point_z", exp_h.point_z, res_if.point_z);
                    if (res_if.hit)
                        hits_seen++;
                end
            end
            if (hold_req > 0)
            begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
                                                           : $urandom_range(0, 2);
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    task automatic test_reset_ray();
        send_box(mk_box(16'h0000, -Q, -Q, -Q, Q, Q, Q, 32'h1, 1'b0));
        send_box(mk_box(16'h0001, Q / 2, -Q, -Q, 2 * Q, Q, Q, 32'h2, 1'b0));
        send_box(mk_box(16'h0002, 2 * Q, -Q, -Q, 3 * Q, Q, Q, 32'h4, 1'b0));
        send_box(mk_box(16'h0003, -3 * Q, -Q, -Q, -2 * Q, Q, Q, 32'h8, 1'b0));
        send_box(mk_box(16'h0004, Q / 2, Q, -Q, 2 * Q, 2 * Q, Q, 32'h10, 1'b0));
        send_box(mk_box(16'h0005, -Q, -Q, -Q, Q, Q, Q, 32'h20, 1'b1));
        send_box(mk_box(16'h0006, 2 * Q, Q, Q, Q / 2, -Q, -Q, 32'h40, 1'b0));
        send_box(mk_box(16'h0007, 0, 0, 0, 0, 0, 0, 32'h80, 1'b0));
        send_box(mk_box(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_box(mk_box(16'h0009, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 1'b0));
        send_box(mk_box(16'h000A, Q, -Q, -Q, 2 * Q, Q, Q, 32'h1, 1'b0));
        drain();
    endtask

    task automatic test_directed_rays();
        apply_ray(coord_t'(3 * Q), coord_t'(Q), coord_t'(0), dir_t'(-65536), dir_t'(0),
                  dir_t'(0), dist_t'(32'h7FFF_FFFF), {1'b1, 32'h0000_00F0});
        send_box(mk_box(16'h0100, Q, 0, -Q, 2 * Q, 2 * Q, Q, 32'h10, 1'b1));
        send_box(mk_box(16'h0101, Q, 0, -Q, 2 * Q, 2 * Q, Q, 32'h01, 1'b0));
        send_box(mk_box(16'h0102, -30000 * Q, 0, -Q, -29999 * Q, 2 * Q, Q, 32'h80, 1'b0));
        send_box(mk_box(16'h0103, 4 * Q, 0, -Q, 5 * Q, 2 * Q, Q, 32'hF0, 1'b0));
        send_box(mk_box(16'h0104, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        drain();
        apply_ray(coord_t'(32'h8000_0000), coord_t'(32'h7FFF_FFFF), coord_t'(0),
                  dir_t'(37837), dir_t'(-37837), dir_t'(37837), dist_t'(1), {1'b0, 32'hFFFF_FFFF});
        send_box(mk_box(16'h0200, 32'h8000_0000, 32'h7FFF_0000, -Q, 32'h8001_0000,
                        32'h7FFF_FFFF, Q, 32'h1, 1'b0));
        send_box(mk_box(16'h0201, 32'h8000_0001, 32'h7FFF_0000, 0, 32'h8001_0000,
                        32'h7FFF_FFFF, Q, 32'h1, 1'b0));
        send_box(mk_box(16'h0202, 32'h8000_0000, 32'h7FFF_0000, 1, 32'h8001_0000,
                        32'h7FFF_FFFF, Q, 32'h1, 1'b0));
        drain();
        apply_ray(coord_t'(-Q), coord_t'(-Q), coord_t'(-Q), dir_t'(-131072),
                  dir_t'(131071), dir_t'(1), dist_t'(64 * Q), {1'b1, 32'h0});
        send_box(mk_box(16'h0300, -8 * Q, -8 * Q, -8 * Q, 8 * Q, 8 * Q, 8 * Q, 32'h1, 1'b0));
        send_box(mk_box(16'h0301, -4 * Q, Q, -Q, -2 * Q, 3 * Q, 5 * Q, 32'h1, 1'b1));
        drain();
    endtask

    task automatic test_random_rays(int phases, int per_phase);
        for (int k = 0; k < phases; k++)
        begin
            quiet = (k % 4 == 3);
            apply_ray(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(),
                      rand_dir(), rand_max(), {1'($urandom), $urandom});
            repeat (per_phase) send_box(rand_box());
            drain();
        end
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        apply_ray(coord_t'(0), coord_t'(0), coord_t'(0), dir_t'(46341), dir_t'(46341),
                  dir_t'(0), dist_t'(8 * Q), {1'b1, 32'hFFFF_FFFF});
        quiet    = 1'b1;
        hold_req = 300;
        repeat (60) send_box(rand_box());
        drain();
        hold_req = 120;
        repeat (40) send_box(rand_box());
        quiet = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_ORIGIN_X;
        cfg_data           = '0;
        body_if.valid      = 1'b0;
        body_if.body_id    = '0;
        body_if.min_x      = '0;
        body_if.min_y      = '0;
        body_if.min_z      = '0;
        body_if.max_x      = '0;
        body_if.max_y      = '0;
        body_if.max_z      = '0;
        body_if.body_layer = '0;
        body_if.is_trigger = 1'b0;
        ray_ox = '0; ray_oy = '0; ray_oz = '0;
        ray_dx = DIR_ONE; ray_dy = '0; ray_dz = '0;
        ray_max    = MAX_DIST_RST;
        ray_filter = FILTER_RST;
        errors = 0; boxes_sent = 0; hits_seen = 0; ray_settings = 1;
        hold_req = 0; quiet = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_ray();
        test_directed_rays();
        test_random_rays(6, 50);
        test_backpressure();
        test_random_rays(2, 25);

        $display("Sent %0d box items over %0d ray settings; %0d results were hits.",
                 boxes_sent, ray_settings, hits_seen);
        if (errors == 0)
            $display("ray_box_slab_test: match");
        else
            $display("ray_box_slab_test: mismatch");
        $finish;
    end

endmodule

FILE: ray_box_slab_test.f
rtl/rbs_pkg.sv
rtl/rbs_if.sv
rtl/rbs_cfg.sv
rtl/rbs_div.sv
rtl/rbs_slab.sv
rtl/rbs_point.sv
rtl/ray_box_slab_test.sv
rtl/rbs_chk.sv
dv/ray_box_slab_test_test.sv
